/* design/aev_pkg.sv */
// Shared types, constants and a helper function for the anisotropic variogram pipeline.
package aev_pkg;

  typedef struct packed {
    logic signed [31:0] sample_x;
    logic signed [31:0] sample_y;
    logic signed [31:0] sample_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
  } pair_t;

  typedef struct packed {
    logic [31:0] semivariance;
    logic        lag_saturated;
  } result_t;

  typedef enum logic [2:0] {
    CFG_COS_ANGLE   = 3'd0,
    CFG_SIN_ANGLE   = 3'd1,
    CFG_INV_RANGE_X = 3'd2,
    CFG_INV_RANGE_Y = 3'd3,
    CFG_INV_RANGE_Z = 3'd4,
    CFG_SILL_LEVEL  = 3'd5
  } cfg_reg_t;

  // Geometry registers handed to the lag front end
  typedef struct packed {
    logic signed [17:0] cos_angle;
    logic signed [17:0] sin_angle;
    logic [31:0]        inv_range_x;
    logic [31:0]        inv_range_y;
    logic [31:0]        inv_range_z;
  } geom_cfg_t;

  typedef struct packed {
    logic [61:0] radicand;
    logic        clip;
  } lag_t;

  typedef struct packed {
    logic [30:0] h;
    logic        clip;
  } hval_t;

  typedef struct packed {
    logic [32:0] e;
    logic        clip;
  } expv_t;

  typedef struct packed {
    logic [61:0] rem;
    logic [62:0] root;
  } sqrt_state_t;

  localparam logic [29:0] LAG_MAX = 30'h3FFF_FFFF;
  localparam logic [30:0] EXP_M1  = 31'd1580030169;
  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

  localparam int SERIES_TERMS         = 13;
  localparam int POWER_STEPS          = 31;
  localparam int SQRT_STAGES          = 8;
  localparam int SQRT_STEPS_PER_STAGE = 4;

  // One digit of the bit-pair square root, trial bit at 2^(2*j)
  function automatic sqrt_state_t sqrt_step(input sqrt_state_t s, input int unsigned j);
    logic [62:0] bitv;
    logic [63:0] trial;
    sqrt_state_t r;
    bitv   = 63'(1) << (2 * j);
    trial  = {1'b0, s.root} + {1'b0, bitv};
    r.rem  = s.rem;
    r.root = s.root >> 1;
    if ({2'b00, s.rem} >= trial) begin
      r.rem  = s.rem - trial[61:0];
      r.root = (s.root >> 1) + bitv;
    end
    return r;
  endfunction

endpackage

/* design/aev_lag.sv */
// Front end: axis differences, rotation, range scaling, clipping and sum of squares.
module aev_lag import aev_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      adv,
  input  logic      in_valid,
  input  pair_t     pair,
  input  geom_cfg_t geom,
  output logic      out_valid,
  output lag_t      lag
);

  localparam int Depth = 8;

  logic [Depth-1:0]   vld;
  logic signed [32:0] dx, dy, dz;
  logic signed [50:0] pxc, pys, pxs, pyc;
  logic [48:0]        az2, az3;
  logic signed [51:0] rx, ry;
  logic [50:0]        amag [3];
  logic [63:0]        plo [3];
  logic [50:0]        phi [3];
  logic [31:0]        inv [3];
  logic [29:0]        u [3];
  logic [59:0]        sq [3];
  logic               clip6, clip7;
  logic [32:0]        dzmag;
  logic [51:0]        ssum [3];
  logic [2:0]         over;

  always_comb begin
    inv[0] = geom.inv_range_x;
    inv[1] = geom.inv_range_y;
    inv[2] = geom.inv_range_z;
    dzmag  = dz[32] ? 33'(-dz) : 33'(dz);
    for (int i = 0; i < 3; i++) begin
      // floor(a * inv / 2^32) rebuilt from high and low partial products
      ssum[i] = 52'(phi[i]) + 52'(plo[i][63:32]);
      over[i] = ssum[i] > 52'(LAG_MAX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Depth-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx <= 33'(pair.sample_x) - 33'(pair.target_x);
      dy <= 33'(pair.sample_y) - 33'(pair.target_y);
      dz <= 33'(pair.sample_z) - 33'(pair.target_z);

      pxc <= 51'(dx) * 51'(geom.cos_angle);
      pys <= 51'(dy) * 51'(geom.sin_angle);
      pxs <= 51'(dx) * 51'(geom.sin_angle);
      pyc <= 51'(dy) * 51'(geom.cos_angle);
      az2 <= {dzmag, 16'd0};

      rx  <= 52'(pxc) - 52'(pys);
      ry  <= 52'(pxs) + 52'(pyc);
      az3 <= az2;

      amag[0] <= rx[51] ? 51'(-rx) : 51'(rx);
      amag[1] <= ry[51] ? 51'(-ry) : 51'(ry);
      amag[2] <= 51'(az3);

      for (int i = 0; i < 3; i++) begin
        plo[i] <= 64'(amag[i][31:0]) * 64'(inv[i]);
        phi[i] <= 51'(amag[i][50:32]) * 51'(inv[i]);
        u[i]   <= over[i] ? LAG_MAX : ssum[i][29:0];
        sq[i]  <= 60'(u[i]) * 60'(u[i]);
      end
      clip6 <= |over;
      clip7 <= clip6;

      lag.radicand <= 62'(sq[0]) + 62'(sq[1]) + 62'(sq[2]);
      lag.clip     <= clip7;
    end
  end

  assign out_valid = vld[Depth-1];

endmodule

/* design/aev_isqrt.sv */
// Pipelined integer square root of the summed squared lags.
module aev_isqrt import aev_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  adv,
  input  logic  in_valid,
  input  lag_t  lag,
  output logic  out_valid,
  output hval_t hval
);

  localparam int TopStep = SQRT_STAGES * SQRT_STEPS_PER_STAGE - 1;

  logic [SQRT_STAGES-1:0] vld;
  sqrt_state_t            st [SQRT_STAGES];
  logic                   cl [SQRT_STAGES];

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
    sqrt_state_t s_in, s_out;
    logic        c_in;

    if (g == 0) begin : g_first
      assign s_in = {lag.radicand, 63'd0};
      assign c_in = lag.clip;
    end else begin : g_rest
      assign s_in = st[g-1];
      assign c_in = cl[g-1];
    end

    always_comb begin
      s_out = s_in;
      for (int k = 0; k < SQRT_STEPS_PER_STAGE; k++) begin
        s_out = sqrt_step(s_out, TopStep - SQRT_STEPS_PER_STAGE * g - k);
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[g] <= s_out;
        cl[g] <= c_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[SQRT_STAGES-2:0], in_valid};
    end
  end

  assign out_valid = vld[SQRT_STAGES-1];
  assign hval      = {st[SQRT_STAGES-1].root[30:0], cl[SQRT_STAGES-1]};

endmodule

/* design/aev_exp.sv */
// exp(-h) in Q1.32: Taylor series on the fraction, then repeated exp(-1) steps.
module aev_exp import aev_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  adv,
  input  logic  in_valid,
  input  hval_t hval,
  output logic  out_valid,
  output expv_t expv
);

  localparam int Terms = SERIES_TERMS - 1;
  localparam int Depth = 2 + 3 * Terms + POWER_STEPS;

  typedef struct packed {
    logic [32:0] sum;
    logic [31:0] term;
    logic [31:0] y;
    logic [63:0] wide;
    logic [4:0]  nn;
    logic        big;
    logic        clip;
  } ser_t;

  typedef struct packed {
    logic [32:0] sum;
    logic [4:0]  nn;
    logic        big;
    logic        clip;
  } pow_t;

  logic [Depth-1:0] vld;
  ser_t             e0;
  ser_t             sa [Terms];
  ser_t             sb [Terms];
  ser_t             sc [Terms];
  pow_t             pf;
  pow_t             pw [POWER_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Depth-2:0], in_valid};
    end
  end

  // First term is y itself; it is folded into the sum by the next stage
  always_ff @(posedge clk) begin
    if (adv) begin
      e0.sum  <= ONE_Q32;
      e0.term <= {hval.h[15:0], 16'd0};
      e0.y    <= {hval.h[15:0], 16'd0};
      e0.wide <= '0;
      e0.nn   <= hval.h[20:16];
      e0.big  <= |hval.h[30:21];
      e0.clip <= hval.clip;
    end
  end

  for (genvar g = 0; g < Terms; g++) begin : g_term
    localparam int          K     = g + 2;
    localparam logic [31:0] RECIP = 32'(64'd4294967296 / K);
    ser_t        prev, a_n, b_n, c_n;
    logic [31:0] q0, qc;
    logic [35:0] rem;

    if (g == 0) begin : g_first
      assign prev = e0;
    end else begin : g_rest
      assign prev = sc[g-1];
    end

    always_comb begin
      a_n      = prev;
      a_n.sum  = ((K - 1) % 2 == 1) ? prev.sum - 33'(prev.term) : prev.sum + 33'(prev.term);
      a_n.wide = 64'(prev.term) * 64'(prev.y);

      b_n      = sa[g];
      b_n.term = sa[g].wide[63:32];
      b_n.wide = 64'(sa[g].wide[63:32]) * 64'(RECIP);

      // reciprocal estimate is low by at most one
      c_n      = sb[g];
      q0       = sb[g].wide[63:32];
      rem      = 36'(sb[g].term) - 36'(q0) * 36'(K);
      qc       = (rem >= 36'(K)) ? q0 + 32'd1 : q0;
      c_n.term = qc;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sa[g] <= a_n;
        sb[g] <= b_n;
        sc[g] <= c_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pf.sum  <= (SERIES_TERMS % 2 == 1) ? sc[Terms-1].sum - 33'(sc[Terms-1].term)
                                         : sc[Terms-1].sum + 33'(sc[Terms-1].term);
      pf.nn   <= sc[Terms-1].nn;
      pf.big  <= sc[Terms-1].big;
      pf.clip <= sc[Terms-1].clip;
    end
  end

  for (genvar i = 0; i < POWER_STEPS; i++) begin : g_pow
    pow_t        prevp, next;
    logic [63:0] wide;

    if (i == 0) begin : g_first
      assign prevp = pf;
    end else begin : g_rest
      assign prevp = pw[i-1];
    end

    always_comb begin
      wide = 64'(prevp.sum) * 64'(EXP_M1);
      next = prevp;
      if (5'(i) < prevp.nn) begin
        next.sum = 33'(wide[63:32]);
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pw[i] <= next;
      end
    end
  end

  assign out_valid = vld[Depth-1];
  assign expv.e    = pw[POWER_STEPS-1].big ? 33'd0 : pw[POWER_STEPS-1].sum;
  assign expv.clip = pw[POWER_STEPS-1].clip;

endmodule

/* design/anisotropic_exponential_variogram_unit.sv */
// Anisotropic exponential variogram: point pair in, semivariance out, fully pipelined.
//
// Input channel pair_valid/pair_stall/pair carries one sample/target point pair per
// transaction (Q24.8 coordinates). Output channel result_valid/result_stall/result
// returns sill*(1-exp(-h)) in Q16.16 with a flag set when any scaled axis lag clipped.
// Configuration writes use cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is always
// high, indexes above the six registers are dropped. Write only while the pipe is empty.
//
// The path from input transaction to result_valid runs through 8 front-end stages,
// 8 square-root stages (4 root digits each), 69 exponential stages (an entry stage,
// 3 per series term after the first for the multiply, reciprocal multiply and
// quotient fix, a closing add, then 31 exp(-1) steps), one final sill multiply and
// the output register. One pair is accepted every cycle while the pipe is not held.
//
// Reset (rst, synchronous) clears all valid bits and loads cos=1.0, sin=0, unit
// reciprocal ranges and unit sill. When result_valid is high and result_stall is
// asserted the whole pipe holds and pair_stall is raised; nothing is dropped.
module anisotropic_exponential_variogram_unit import aev_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        pair_valid,
  output logic        pair_stall,
  input  pair_t       pair,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic signed [17:0] cos_angle, sin_angle;
  logic [31:0]        inv_range_x, inv_range_y, inv_range_z, sill_level;
  geom_cfg_t          geom;
  logic               adv;
  logic               lag_valid, h_valid, x_valid, m_valid;
  lag_t               lag;
  hval_t              hval;
  expv_t              expv;
  logic [32:0]        one_minus_e;
  logic [63:0]        mprod;
  logic               mclip;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_angle   <= 18'sh10000;
      sin_angle   <= '0;
      inv_range_x <= 32'h0100_0000;
      inv_range_y <= 32'h0100_0000;
      inv_range_z <= 32'h0100_0000;
      sill_level  <= 32'h0001_0000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_COS_ANGLE:   cos_angle   <= cfg_data[17:0];
        CFG_SIN_ANGLE:   sin_angle   <= cfg_data[17:0];
        CFG_INV_RANGE_X: inv_range_x <= cfg_data;
        CFG_INV_RANGE_Y: inv_range_y <= cfg_data;
        CFG_INV_RANGE_Z: inv_range_z <= cfg_data;
        CFG_SILL_LEVEL:  sill_level  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign geom = '{cos_angle: cos_angle, sin_angle: sin_angle, inv_range_x: inv_range_x,
                  inv_range_y: inv_range_y, inv_range_z: inv_range_z};

  // Global advance: the pipe only holds while a finished result is refused
  assign adv        = !(result_valid && result_stall);
  assign pair_stall = !adv;

  aev_lag u_lag (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (pair_valid),
    .pair      (pair),
    .geom      (geom),
    .out_valid (lag_valid),
    .lag       (lag)
  );

  aev_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (lag_valid),
    .lag       (lag),
    .out_valid (h_valid),
    .hval      (hval)
  );

  aev_exp u_exp (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (h_valid),
    .hval      (hval),
    .out_valid (x_valid),
    .expv      (expv)
  );

  assign one_minus_e = ONE_Q32 - expv.e;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid      <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      m_valid      <= x_valid;
      result_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mprod                <= 64'(sill_level) * 64'(one_minus_e);
      mclip                <= expv.clip;
      result.semivariance  <= mprod[63:32];
      result.lag_saturated <= mclip;
    end
  end

  a_within_sill: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.semivariance <= sill_level)
    else $error("semivariance above sill");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  a_hold_pipe: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(m_valid) && $stable(x_valid))
    else $error("pipe moved while output held");

endmodule
